@@ sv/spf_pkg.sv @@
`default_nettype none
package spf_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;
    localparam int SEQ_W         = 32;
    localparam int IDX_W         = 16;
    localparam int PPP_W         = 13;
    localparam int CFG_AW        = 2;
    localparam int CFG_DW        = 16;
    localparam int DEF_MAX_PAIRS = 4096;

    localparam logic [BYTE_W-1:0] OPEN_BYTE_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] CLOSE_BYTE_RST = 8'd85;
    localparam logic [LEN_W-1:0]  LENGTH_RST     = 16'd0;
    localparam logic [PPP_W-1:0]  PAIRS_RST      = 13'd64;

    // Descriptor queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic [CFG_AW-1:0] {
        REG_OPEN_BYTE   = 2'd0,
        REG_CLOSE_BYTE  = 2'd1,
        REG_LENGTH_WORD = 2'd2,
        REG_PAIRS       = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_LEN_HI = 4'd1,
        ST_LEN_LO = 4'd2,
        ST_SEQ_3  = 4'd3,
        ST_SEQ_2  = 4'd4,
        ST_SEQ_1  = 4'd5,
        ST_SEQ_0  = 4'd6,
        ST_IDX_HI = 4'd7,
        ST_IDX_LO = 4'd8,
        ST_SMP_HI = 4'd9,
        ST_SMP_LO = 4'd10,
        ST_END    = 4'd11
    } step_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    index;
        logic [SEQ_W-1:0]    seq;
        logic                hdr;
        logic                tail;
    } desc_t;

    typedef struct packed {
        logic [BYTE_W-1:0] open_byte;
        logic [BYTE_W-1:0] close_byte;
        logic [LEN_W-1:0]  length_word;
    } frame_cfg_t;

endpackage
`default_nettype wire

@@ sv/spf_front.sv @@
`default_nettype none
module spf_front
    import spf_pkg::*;
#(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [PPP_W-1:0]    pairs_per_packet,
    output logic                     q_wr,
    output desc_t                    q_desc,
    input  wire logic                q_full
);

    localparam int POS_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CMP_W = (PPP_W > POS_W + 1) ? PPP_W : POS_W + 1;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_PAIRS);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [CMP_W-1:0] ppp_ext, eff_pairs, pos_inc;
    logic             tail;

    assign full = q_full;
    assign q_wr = push && !q_full;

    // A zero count means one pair; counts above the limit saturate.
    always_comb
    begin
        ppp_ext = CMP_W'(pairs_per_packet);
        if (ppp_ext == '0)
            eff_pairs = CMP_W'(1);
        else if (ppp_ext > MAX_EXT)
            eff_pairs = MAX_EXT;
        else
            eff_pairs = ppp_ext;
        pos_inc = CMP_W'(pos_reg) + CMP_W'(1);
        tail    = (pos_inc >= eff_pairs);
    end

    always_comb
    begin
        q_desc.sample = sample;
        q_desc.index  = IDX_W'(pos_reg);
        q_desc.seq    = seq_reg;
        q_desc.hdr    = (pos_reg == '0);
        q_desc.tail   = tail;
    end

    always_comb
    begin
        pos_next = pos_reg;
        seq_next = seq_reg;
        if (q_wr)
        begin
            if (tail)
            begin
                pos_next = '0;
                seq_next = seq_reg + SEQ_W'(1);
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            seq_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            seq_reg <= seq_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/spf_queue.sv @@
`default_nettype none
module spf_queue
    import spf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr,
    input  wire desc_t wdata,
    output logic       full,
    input  wire logic  rd,
    output desc_t      rdata,
    output logic       empty
);

    desc_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + Q_CW'(1);
        else if (rd && !wr)
            count_next = count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/spf_back.sv @@
`default_nettype none
module spf_back
    import spf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire frame_cfg_t         cfg,
    input  wire logic               q_empty,
    input  wire desc_t              q_desc,
    output logic                    q_rd,
    output logic                    empty,
    input  wire logic               pop,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    packet_end,
    output logic                    run_last
);

    step_t             step_reg, step_next, cur_step, last_step;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              packet_end_reg, run_last_reg;
    logic              emit;
    logic [BYTE_W-1:0] byte_sel;

    // The output register takes a new beat when it is free or being drained.
    assign emit      = !q_empty && (!out_valid_reg || pop);
    assign cur_step  = started_reg ? step_reg : (q_desc.hdr ? ST_START : ST_IDX_HI);
    assign last_step = q_desc.tail ? ST_END : ST_SMP_LO;
    assign q_rd      = emit && (cur_step == last_step);

    always_comb
    begin
        unique case (cur_step)
            ST_START:  byte_sel = cfg.open_byte;
            ST_LEN_HI: byte_sel = cfg.length_word[15:8];
            ST_LEN_LO: byte_sel = cfg.length_word[7:0];
            ST_SEQ_3:  byte_sel = q_desc.seq[31:24];
            ST_SEQ_2:  byte_sel = q_desc.seq[23:16];
            ST_SEQ_1:  byte_sel = q_desc.seq[15:8];
            ST_SEQ_0:  byte_sel = q_desc.seq[7:0];
            ST_IDX_HI: byte_sel = q_desc.index[15:8];
            ST_IDX_LO: byte_sel = q_desc.index[7:0];
            ST_SMP_HI: byte_sel = q_desc.sample[15:8];
            ST_SMP_LO: byte_sel = q_desc.sample[7:0];
            ST_END:    byte_sel = cfg.close_byte;
            default:   byte_sel = '0;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (q_rd)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                step_next    = step_t'(cur_step + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_START;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= byte_sel;
            packet_end_reg <= (cur_step == ST_END);
            run_last_reg   <= q_rd;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign packet_end = packet_end_reg;
    assign run_last   = run_last_reg;

endmodule
`default_nettype wire

@@ sv/sample_packet_framer.sv @@
// Channel  | Handshake           | Beat contents
// ---------+---------------------+-----------------------------------------
// input    | push / full         | sample
// result   | pop / empty         | out_byte, packet_end, run_last
// config   | cfg_we (no wait)    | cfg_idx, cfg_wdata
//
// The back end sends one byte per cycle while a sample waits and the receiver
// pops, so a sample takes 4 bytes, 5 when it closes a packet, 11 when it opens one and 12 when it does both.
// The front classifies a sample in the cycle it is pushed and parks it in a
// two-entry descriptor queue, so input and output stall independently.
// Reset clears the packet position and sequence number and loads the
// register defaults; the queue starts empty, so the first push is not held off.
`default_nettype none
module sample_packet_framer
    import spf_pkg::*;
#(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     empty,
    input  wire logic                pop,
    output logic [BYTE_W-1:0]        out_byte,
    output logic                     packet_end,
    output logic                     run_last,
    input  wire logic                cfg_we,
    input  wire logic [CFG_AW-1:0]   cfg_idx,
    input  wire logic [CFG_DW-1:0]   cfg_wdata
);

    logic [BYTE_W-1:0] open_byte_reg, close_byte_reg;
    logic [LEN_W-1:0]  length_word_reg;
    logic [PPP_W-1:0]  pairs_reg;
    frame_cfg_t        frame_cfg;
    desc_t             q_wdesc, q_rdesc;
    logic              q_wr, q_rd, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_byte_reg   <= OPEN_BYTE_RST;
            close_byte_reg  <= CLOSE_BYTE_RST;
            length_word_reg <= LENGTH_RST;
            pairs_reg       <= PAIRS_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_idx))
                REG_OPEN_BYTE:   open_byte_reg   <= cfg_wdata[BYTE_W-1:0];
                REG_CLOSE_BYTE:  close_byte_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_LENGTH_WORD: length_word_reg <= cfg_wdata[LEN_W-1:0];
                REG_PAIRS:       pairs_reg       <= cfg_wdata[PPP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        frame_cfg.open_byte   = open_byte_reg;
        frame_cfg.close_byte  = close_byte_reg;
        frame_cfg.length_word = length_word_reg;
    end

    spf_front #(
        .MAX_PAIRS(MAX_PAIRS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .sample          (sample),
        .pairs_per_packet(pairs_reg),
        .q_wr            (q_wr),
        .q_desc          (q_wdesc),
        .q_full          (q_full)
    );

    spf_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (q_wr),
        .wdata(q_wdesc),
        .full (q_full),
        .rd   (q_rd),
        .rdata(q_rdesc),
        .empty(q_empty)
    );

    spf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (frame_cfg),
        .q_empty   (q_empty),
        .q_desc    (q_rdesc),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .packet_end(packet_end),
        .run_last  (run_last)
    );

    // The end code is always the final beat of its sample.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_end) |-> run_last)
        else $error("end code beat without run_last");

    // A header is requested exactly when the pair index is zero.
    a_hdr_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> ((q_wdesc.index == '0) == q_wdesc.hdr))
        else $error("header flag disagrees with pair index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> (32'(q_wdesc.index) < 32'(MAX_PAIRS)))
        else $error("pair index beyond limit");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("descriptor queue both full and empty");

endmodule
`default_nettype wire

@@ tb/sample_packet_framer_tb.sv @@
`default_nettype none
module sample_packet_framer_tb;
    import spf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_STALL_CYCLES = 300;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eop;
        logic              last;
    } beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                packet_end;
    logic                run_last;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_idx = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;

    sample_packet_framer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata)
    );

    // Framer state and registers as the testbench sees them.
    logic [BYTE_W-1:0] start_byte = OPEN_BYTE_RST;
    logic [BYTE_W-1:0] end_byte = CLOSE_BYTE_RST;
    logic [LEN_W-1:0]  len_word = LENGTH_RST;
    logic [PPP_W-1:0]  pair_limit = PAIRS_RST;
    logic [SEQ_W-1:0]  seq_count = '0;
    logic [11:0]       pair_pos = '0;

    logic [SAMPLE_W-1:0] samples_waiting[$];
    beat_t               beats_due[$];
    beat_t               want;

    int  tx_gap_max = 15;
    int  rx_gap_max = 15;
    bit  tx_pause = 1'b0;
    bit  stall_kick = 1'b0;
    int  stall_left = 0;
    int  push_wait = 0;
    int  pop_wait = 0;
    int  tx_draw;
    int  rx_draw;
    int  idle_cycles = 0;
    int  mismatches = 0;
    int  samples_framed = 0;
    int  bytes_checked = 0;
    int  packets_closed = 0;
    int  reg_writes = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    // Works out the bytes one accepted sample must produce and advances
    // the packet position and sequence number.
    task automatic frame_sample(input logic [SAMPLE_W-1:0] s);
        logic [BYTE_W-1:0] bytes_out[$];
        logic [IDX_W-1:0]  idx;
        int                limit;
        bit                closes;
        limit = (pair_limit == 0) ? 1 :
                ((pair_limit > DEF_MAX_PAIRS) ? DEF_MAX_PAIRS : int'(pair_limit));
        idx = {4'd0, pair_pos};
        if (pair_pos == 0)
        begin
            bytes_out = {start_byte, len_word[15:8], len_word[7:0], seq_count[31:24],
                         seq_count[23:16], seq_count[15:8], seq_count[7:0]};
        end
        bytes_out.push_back(idx[15:8]);
        bytes_out.push_back(idx[7:0]);
        bytes_out.push_back(s[15:8]);
        bytes_out.push_back(s[7:0]);
        closes = (int'(pair_pos) + 1 >= limit);
        foreach (bytes_out[i])
        begin
            beats_due.push_back('{data: bytes_out[i], eop: 1'b0,
                                  last: (i == bytes_out.size() - 1) && !closes});
        end
        if (closes)
        begin
            beats_due.push_back('{data: end_byte, eop: 1'b1, last: 1'b1});
            seq_count = seq_count + 32'd1;
            pair_pos = '0;
        end
        else
        begin
            pair_pos = pair_pos + 12'd1;
        end
    endtask

    // Sender: offers queued samples, with a random gap after each beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            sample <= '0;
            push_wait <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                frame_sample(sample);
                samples_framed++;
                tx_draw = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            end
            else
            begin
                tx_draw = push_wait;
            end
            if (!push || !full)
            begin
                if (tx_draw > 0)
                begin
                    push <= 1'b0;
                    push_wait <= tx_draw - 1;
                end
                else if (samples_waiting.size() > 0 && !tx_pause)
                begin
                    push <= 1'b1;
                    sample <= samples_waiting.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started by a one-cycle kick.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_kick)
            stall_left <= RX_STALL_CYCLES;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
    end

    // Receiver: checks each byte beat against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_wait <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                bytes_checked++;
                if (packet_end === 1'b1)
                    packets_closed++;
                if (beats_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected beat: byte %02h end %b last %b",
                                 out_byte, packet_end, run_last);
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (out_byte !== want.data || packet_end !== want.eop ||
                        run_last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Beat %0d: expected byte %02h end %b last %b, got %02h %b %b",
                                     bytes_checked, want.data, want.eop, want.last,
                                     out_byte, packet_end, run_last);
                    end
                end
                rx_draw = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
                pop_wait <= rx_draw;
                pop <= (rx_draw == 0) && (stall_left == 0);
            end
            else if (pop_wait > 0)
            begin
                pop_wait <= pop_wait - 1;
                pop <= (pop_wait == 1) && (stall_left == 0);
            end
            else
            begin
                pop <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat moved for %0d cycles, %0d bytes still due",
                         idle_cycles, beats_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OPEN_BYTE:   start_byte = value[7:0];
            REG_CLOSE_BYTE:  end_byte = value[7:0];
            REG_LENGTH_WORD: len_word = value;
            REG_PAIRS:       pair_limit = value[PPP_W-1:0];
            default:         ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (samples_waiting.size() != 0 || push || beats_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        int count;
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: header with the default open code, full-scale samples.
        samples_waiting = {16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE};
        wait_idle();

        // A pair count of zero acts as one pair, so every sample is a packet.
        write_reg(REG_OPEN_BYTE, 16'h0000);
        write_reg(REG_CLOSE_BYTE, 16'h00FF);
        write_reg(REG_LENGTH_WORD, 16'hFFFF);
        write_reg(REG_PAIRS, 16'd0);
        samples_waiting = {16'hFFFF, 16'h0000, 16'hA55A};
        wait_idle();

        write_reg(REG_OPEN_BYTE, 16'h00FF);
        write_reg(REG_CLOSE_BYTE, 16'h0000);
        write_reg(REG_LENGTH_WORD, 16'h0000);
        write_reg(REG_PAIRS, 16'd1);
        samples_waiting = {16'h1234, 16'hFEDC};
        wait_idle();

        // Lower the pair count below the current position mid-packet.
        write_reg(REG_OPEN_BYTE, 16'h005A);
        write_reg(REG_CLOSE_BYTE, 16'h00A5);
        write_reg(REG_LENGTH_WORD, 16'h1234);
        write_reg(REG_PAIRS, 16'd3);
        samples_waiting = {16'h0F0F, 16'hF0F0};
        wait_idle();
        write_reg(REG_PAIRS, 16'd1);
        samples_waiting.push_back(16'h3C3C);
        wait_idle();

        // Largest count, then lowered so that the current pair meets it exactly.
        write_reg(REG_PAIRS, 16'd4096);
        samples_waiting = {16'h5555, 16'hAAAA};
        wait_idle();
        write_reg(REG_PAIRS, 16'd3);
        samples_waiting = {16'h00FF, 16'hFF00};
        wait_idle();

        // A count beyond the maximum saturates, so these samples stay in one packet.
        write_reg(REG_PAIRS, 16'd8191);
        tx_gap_max = 0;
        rx_gap_max = 0;
        repeat (6) samples_waiting.push_back(SAMPLE_W'($urandom_range(0, 65535)));
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_OPEN_BYTE, CFG_DW'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_CLOSE_BYTE, CFG_DW'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_LENGTH_WORD, CFG_DW'($urandom_range(0, 65535)));
            pick = $urandom_range(0, 7);
            if (pick == 0)
                write_reg(REG_PAIRS, 16'd0);
            else if (pick == 1)
                write_reg(REG_PAIRS, CFG_DW'($urandom_range(9, 40)));
            else
                write_reg(REG_PAIRS, CFG_DW'($urandom_range(1, 8)));
            tx_gap_max = (phase % 3 == 1) ? 0 : 15;
            rx_gap_max = (phase % 2 == 1) ? 0 : 15;
            if (phase == 2)
            begin
                // Receiver holds off while the sender keeps pushing, so full rises.
                tx_gap_max = 0;
                stall_kick = 1'b1;
                @(negedge clk);
                stall_kick = 1'b0;
            end
            count = $urandom_range(22, 40);
            repeat (count) samples_waiting.push_back(SAMPLE_W'($urandom_range(0, 65535)));
            if (phase == 5)
            begin
                while (samples_waiting.size() > count / 2)
                    @(negedge clk);
                tx_pause = 1'b1;
                do
                    @(negedge clk);
                while (push || beats_due.size() != 0);
                repeat (10) @(negedge clk);
                tx_pause = 1'b0;
            end
            wait_idle();
        end

        repeat (40) @(negedge clk);
        if (beats_due.size() != 0)
            mismatches++;
        $display("Framed %0d samples into %0d bytes and %0d closed packets.",
                 samples_framed, bytes_checked, packets_closed);
        $display("%0d register writes, pair counts 0 to 8191, with stalls on both sides.",
                 reg_writes);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
